[src/fxa_pkg.sv]
// ----------------------------------------------------------------------------
// fxa_pkg
// Shared constants and types for the Q24.8 fixed-point ALU.
// ----------------------------------------------------------------------------
package fxa_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int WORD_BITS_DEF = 32;

    typedef enum logic [3:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_GT       = 4'd4,
        CMD_LT       = 4'd5,
        CMD_GE       = 4'd6,
        CMD_LE       = 4'd7,
        CMD_EQ       = 4'd8,
        CMD_NE       = 4'd9,
        CMD_MIN      = 4'd10,
        CMD_MAX      = 4'd11,
        CMD_INC      = 4'd12,
        CMD_DEC      = 4'd13,
        CMD_FROM_INT = 4'd14,
        CMD_TO_INT   = 4'd15
    } t_cmd;

    // per-word status carried down the pipeline
    typedef struct packed {
        logic cmp;
        logic sat;
        logic dz;
        logic neg;
    } t_flags;

endpackage

[src/fxa_div_stage.sv]
// ----------------------------------------------------------------------------
// fxa_div_stage
// One restoring-division step: shift in a numerator bit, trial subtract,
// shift a quotient bit in. Registered, advances on i_en.
// ----------------------------------------------------------------------------
module fxa_div_stage #(
    parameter int WORD_BITS = 32,
    parameter int QUO_BITS  = 40
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [WORD_BITS-1:0] i_rem,
    input  logic [QUO_BITS-1:0]  i_quo,
    input  logic [WORD_BITS-1:0] i_den,
    output logic [WORD_BITS-1:0] o_rem,
    output logic [QUO_BITS-1:0]  o_quo,
    output logic [WORD_BITS-1:0] o_den
);

    logic [WORD_BITS:0]   shifted;
    logic [WORD_BITS+1:0] trial;
    logic [WORD_BITS-1:0] n_rem;
    logic [QUO_BITS-1:0]  n_quo;
    logic [WORD_BITS-1:0] r_rem;
    logic [QUO_BITS-1:0]  r_quo;
    logic [WORD_BITS-1:0] r_den;

    always_comb begin
        shifted = {i_rem, i_quo[QUO_BITS-1]};
        trial   = {1'b0, shifted} - {2'b00, i_den};
        if (!trial[WORD_BITS+1]) begin
            n_rem = trial[WORD_BITS-1:0];
            n_quo = {i_quo[QUO_BITS-2:0], 1'b1};
        end else begin
            n_rem = shifted[WORD_BITS-1:0];
            n_quo = {i_quo[QUO_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_den <= i_den;
        end
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;
    assign o_den = r_den;

endmodule

[src/fixed_point_alu_q24_8.sv]
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8
// Pipelined fixed-point ALU on signed raw words with FRAC_BITS fraction bits.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------------
//   input    | i_in_valid / o_in_ready   | i_command, i_operand_a, i_operand_b
//   output   | o_out_valid / i_out_ready | o_result_value, o_compare_true,
//            |                           | o_saturated, o_divide_by_zero
//
// One word enters per cycle unless the output stalls. The depth is set by the
// divider: one restoring step per stage, between stage 2 and the output.
// All commands travel the same depth, so results leave in input order.
// A stalled output word freezes the whole pipeline; ready is high whenever
// the output register is empty or being taken.
// Reset (synchronous, active low) clears the valid bits only.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8 #(
    parameter int FRAC_BITS = fxa_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = fxa_pkg::WORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [3:0]                  i_command,
    input  logic signed [WORD_BITS-1:0] i_operand_a,
    input  logic signed [WORD_BITS-1:0] i_operand_b,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [WORD_BITS-1:0] o_result_value,
    output logic                        o_compare_true,
    output logic                        o_saturated,
    output logic                        o_divide_by_zero
);
    import fxa_pkg::*;

    localparam int W = WORD_BITS;
    localparam int N = WORD_BITS + FRAC_BITS;   // quotient bits = divider stages
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic [2*W:0] HALF = ((2*W+1)'(1) << FRAC_BITS) >> 1;

    // whole pipeline advances together
    logic en;
    logic r_vo;
    assign en         = !r_vo || i_out_ready;
    assign o_in_ready = en;

    // ---- stage 1: input register ----
    logic         r_v1;
    t_cmd         r_cmd1;
    logic [W-1:0] r_a1, r_b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cmd1 <= t_cmd'(i_command);
            r_a1   <= i_operand_a;
            r_b1   <= i_operand_b;
        end
    end

    // ---- stage 2: simple ops, magnitudes, product ----
    logic [W:0]     sum, dif, incv, decv;
    logic [N-1:0]   fi;
    logic [W-1:0]   mag_a, mag_b, n_res2;
    logic [2*W-1:0] prod;
    logic           a_lt_b, b_lt_a, fi_sat;
    t_flags         n_flg2;

    function automatic logic [W:0] clamp1(input logic [W:0] s);
        // {sat, value} for a sum one bit wider than the word
        if (s[W] != s[W-1]) begin
            clamp1 = {1'b1, (s[W] ? MINV : MAXV)};
        end else begin
            clamp1 = {1'b0, s[W-1:0]};
        end
    endfunction

    always_comb begin
        sum    = {r_a1[W-1], r_a1} + {r_b1[W-1], r_b1};
        dif    = {r_a1[W-1], r_a1} - {r_b1[W-1], r_b1};
        incv   = {r_a1[W-1], r_a1} + (W+1)'(1);
        decv   = {r_a1[W-1], r_a1} - (W+1)'(1);
        fi     = N'(signed'(r_a1)) << FRAC_BITS;
        fi_sat = (fi[N-1:W-1] != '0) && (fi[N-1:W-1] != '1);
        mag_a  = r_a1[W-1] ? (W'(0) - r_a1) : r_a1;
        mag_b  = r_b1[W-1] ? (W'(0) - r_b1) : r_b1;
        prod   = (2*W)'(mag_a) * (2*W)'(mag_b);
        a_lt_b = signed'(r_a1) < signed'(r_b1);
        b_lt_a = signed'(r_b1) < signed'(r_a1);
        n_res2 = '0;
        n_flg2 = '0;
        n_flg2.neg = r_a1[W-1] ^ r_b1[W-1];
        case (r_cmd1)
            CMD_ADD: {n_flg2.sat, n_res2} = clamp1(sum);
            CMD_SUB: {n_flg2.sat, n_res2} = clamp1(dif);
            CMD_MUL: n_res2 = '0;
            CMD_DIV: n_flg2.dz = (r_b1 == '0);
            CMD_GT:  n_flg2.cmp = b_lt_a;
            CMD_LT:  n_flg2.cmp = a_lt_b;
            CMD_GE:  n_flg2.cmp = !a_lt_b;
            CMD_LE:  n_flg2.cmp = !b_lt_a;
            CMD_EQ:  n_flg2.cmp = (r_a1 == r_b1);
            CMD_NE:  n_flg2.cmp = (r_a1 != r_b1);
            CMD_MIN: n_res2 = b_lt_a ? r_b1 : r_a1;
            CMD_MAX: n_res2 = b_lt_a ? r_a1 : r_b1;
            CMD_INC: {n_flg2.sat, n_res2} = clamp1(incv);
            CMD_DEC: {n_flg2.sat, n_res2} = clamp1(decv);
            CMD_FROM_INT: begin
                n_flg2.sat = fi_sat;
                n_res2     = fi_sat ? (r_a1[W-1] ? MINV : MAXV) : fi[W-1:0];
            end
            CMD_TO_INT: n_res2 = W'(signed'(r_a1) >>> FRAC_BITS);
            default: n_res2 = '0;
        endcase
    end

    // sideband travels alongside the divider; index 0 is stage 2
    logic           r_sv   [0:N];
    t_cmd           r_scmd [0:N];
    logic [W-1:0]   r_sres [0:N];
    t_flags         r_sflg [0:N];
    logic [2*W-1:0] r_sprod[0:N];
    logic [W-1:0]   w_rem  [0:N];
    logic [N-1:0]   w_quo  [0:N];
    logic [W-1:0]   w_den  [0:N];
    logic [W-1:0]   r_rem0, r_den0;
    logic [N-1:0]   r_quo0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (en) begin
            r_sv[0] <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_scmd[0]  <= r_cmd1;
            r_sres[0]  <= n_res2;
            r_sflg[0]  <= n_flg2;
            r_sprod[0] <= prod;
            r_rem0     <= '0;
            r_quo0     <= N'(mag_a) << FRAC_BITS;
            r_den0     <= mag_b;
        end
    end

    assign w_rem[0] = r_rem0;
    assign w_quo[0] = r_quo0;
    assign w_den[0] = r_den0;

    // ---- divider stages ----
    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_div
            fxa_div_stage #(
                .WORD_BITS (W),
                .QUO_BITS  (N)
            ) u_stage (
                .i_clk (i_clk),
                .i_en  (en),
                .i_rem (w_rem[k]),
                .i_quo (w_quo[k]),
                .i_den (w_den[k]),
                .o_rem (w_rem[k+1]),
                .o_quo (w_quo[k+1]),
                .o_den (w_den[k+1])
            );

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sv[k+1] <= 1'b0;
                end else if (en) begin
                    r_sv[k+1] <= r_sv[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_scmd[k+1]  <= r_scmd[k];
                    r_sres[k+1]  <= r_sres[k];
                    r_sflg[k+1]  <= r_sflg[k];
                    r_sprod[k+1] <= r_sprod[k];
                end
            end
        end
    endgenerate

    // ---- final stage: round, saturate, select ----
    function automatic logic [W:0] from_mag(input logic neg, input logic [2*W:0] m);
        logic [2*W:0] lim;
        lim = neg ? (2*W+1)'({1'b0, MINV}) : (2*W+1)'(MAXV);
        if (m > lim) begin
            from_mag = {1'b1, (neg ? MINV : MAXV)};
        end else begin
            from_mag = {1'b0, (neg ? (W'(0) - m[W-1:0]) : m[W-1:0])};
        end
    endfunction

    logic [2*W:0] mul_r, div_r;
    logic [W:0]   rem2;
    logic         rnd;
    logic [W-1:0] n_res;
    t_flags       n_flg;

    always_comb begin
        mul_r = ((2*W+1)'(r_sprod[N]) + HALF) >> FRAC_BITS;
        rem2  = {w_rem[N], 1'b0};
        rnd   = (rem2 >= {1'b0, w_den[N]});
        div_r = (2*W+1)'(w_quo[N]) + (2*W+1)'(rnd);
        n_res = r_sres[N];
        n_flg = r_sflg[N];
        case (r_scmd[N])
            CMD_MUL: {n_flg.sat, n_res} = from_mag(r_sflg[N].neg, mul_r);
            CMD_DIV: begin
                if (!r_sflg[N].dz) begin
                    {n_flg.sat, n_res} = from_mag(r_sflg[N].neg, div_r);
                end
            end
            default: n_res = r_sres[N];
        endcase
    end

    logic [W-1:0] r_res_o;
    t_flags       r_flg_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (en) begin
            r_vo <= r_sv[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res_o <= n_res;
            r_flg_o <= n_flg;
        end
    end

    assign o_out_valid      = r_vo;
    assign o_result_value   = r_res_o;
    assign o_compare_true   = r_flg_o.cmp;
    assign o_saturated      = r_flg_o.sat;
    assign o_divide_by_zero = r_flg_o.dz;

    // ---- checks ----
    a_dz_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && r_flg_o.dz) |-> (r_res_o == '0 && !r_flg_o.sat && !r_flg_o.cmp))
        else $error("divide by zero word carries result or flags");

    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && r_flg_o.cmp) |-> (r_res_o == '0 && !r_flg_o.sat))
        else $error("compare word carries a result");

    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && r_flg_o.sat) |-> (r_res_o == MAXV || r_res_o == MINV))
        else $error("saturated word not at a rail");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en) |=> ($stable(r_sv[N]) && $stable(r_scmd[N])))
        else $error("pipeline moved during stall");

endmodule

[tb/fxa_checker.sv]
// ----------------------------------------------------------------------------
// fxa_checker
// Watches both channels of the fixed-point ALU, predicts each result word
// from the accepted input word and compares it field by field.
// ----------------------------------------------------------------------------
module fxa_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [3:0]         i_command,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_result_value,
    input  logic               i_compare_true,
    input  logic               i_saturated,
    input  logic               i_divide_by_zero,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_results
);
    timeunit 1ns;
    timeprecision 1ps;
    import fxa_pkg::*;

    localparam int FB = 8;
    localparam logic signed [63:0] MAXV = 64'sd2147483647;
    localparam logic signed [63:0] MINV = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] value;
        logic        cmp;
        logic        sat;
        logic        dz;
    } t_alu_word;

    t_alu_word alu_words_due[$];

    function automatic logic [31:0] clamp_wide(input logic signed [127:0] v,
                                               output logic sat);
        sat = 1'b0;
        if (v > MAXV) begin
            sat = 1'b1;
            return MAXV[31:0];
        end
        if (v < MINV) begin
            sat = 1'b1;
            return MINV[31:0];
        end
        return v[31:0];
    endfunction

    function automatic t_alu_word alu_predict(input logic [3:0] cmd,
                                              input logic signed [31:0] a,
                                              input logic signed [31:0] b);
        t_alu_word w;
        logic signed [127:0] wa, wb, p, q, n, d;
        logic neg;
        wa = a;
        wb = b;
        w = '0;
        case (t_cmd'(cmd))
            CMD_ADD: w.value = clamp_wide(wa + wb, w.sat);
            CMD_SUB: w.value = clamp_wide(wa - wb, w.sat);
            CMD_MUL: begin
                // round magnitude, halves away from zero
                neg = (a < 0) ^ (b < 0);
                p = (wa < 0 ? -wa : wa) * (wb < 0 ? -wb : wb);
                p = (p + (1 << (FB - 1))) >>> FB;
                w.value = clamp_wide(neg ? -p : p, w.sat);
            end
            CMD_DIV: begin
                if (b == 0) begin
                    w.dz = 1'b1;
                end else begin
                    neg = (a < 0) ^ (b < 0);
                    n = (wa < 0 ? -wa : wa) <<< FB;
                    d = wb < 0 ? -wb : wb;
                    q = n / d;
                    if (2 * (n - q * d) >= d) q = q + 1;
                    w.value = clamp_wide(neg ? -q : q, w.sat);
                end
            end
            CMD_GT:  w.cmp = a > b;
            CMD_LT:  w.cmp = a < b;
            CMD_GE:  w.cmp = a >= b;
            CMD_LE:  w.cmp = a <= b;
            CMD_EQ:  w.cmp = a == b;
            CMD_NE:  w.cmp = a != b;
            CMD_MIN: w.value = (a <= b) ? a : b;
            CMD_MAX: w.value = (a > b) ? a : b;
            CMD_INC: w.value = clamp_wide(wa + 1, w.sat);
            CMD_DEC: w.value = clamp_wide(wa - 1, w.sat);
            CMD_FROM_INT: w.value = clamp_wide(wa <<< FB, w.sat);
            default: w.value = a >>> FB;
        endcase
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_alu_word got, want;
        if (!i_rst_n) begin
            alu_words_due.delete();
            o_errors  <= 0;
            o_results <= 0;
            o_pending <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                alu_words_due.push_back(alu_predict(i_command, i_operand_a, i_operand_b));
            if (i_out_valid && i_out_ready) begin
                got = '{i_result_value, i_compare_true, i_saturated, i_divide_by_zero};
                o_results <= o_results + 1;
                if (alu_words_due.size() == 0) begin
                    $display("%0t: unexpected word, actual %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = alu_words_due.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch value exp %h act %h cmp %b/%b sat %b/%b dz %b/%b",
                                 $time, want.value, got.value, want.cmp, got.cmp,
                                 want.sat, got.sat, want.dz, got.dz);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= alu_words_due.size();
        end
    end
endmodule

[tb/tb_fixed_point_alu_q24_8.sv]
// ----------------------------------------------------------------------------
// tb_fixed_point_alu_q24_8
// Drives directed and random words into the fixed-point ALU with random
// gaps and output stalls; the checker predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_fixed_point_alu_q24_8;
    timeunit 1ns;
    timeprecision 1ps;
    import fxa_pkg::*;

    localparam int LATENCY   = 43;
    localparam int N_RANDOM  = 700;
    localparam int MAX_CYCLE = 200000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [3:0]         i_command = '0;
    logic signed [31:0] i_operand_a = '0;
    logic signed [31:0] i_operand_b = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_result_value;
    logic               o_compare_true, o_saturated, o_divide_by_zero;

    int  errors, pending, results;
    int  cycle_count = 0;
    bit  calm = 1'b0;       // long stretch without idling on either side
    int  words_sent = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    fixed_point_alu_q24_8 u_dut (.*);

    fxa_checker u_chk (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_command,
        .i_operand_a, .i_operand_b, .i_out_valid(o_out_valid), .i_out_ready,
        .i_result_value(o_result_value), .i_compare_true(o_compare_true),
        .i_saturated(o_saturated), .i_divide_by_zero(o_divide_by_zero),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stalls at random (9 percent odds) outside the calm stretch
    always @(negedge i_clk)
        i_out_ready <= calm || ($urandom_range(99) >= 9);

    // corner values mixed into random operands
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return $urandom_range(1023) - 512;
            4: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
            5: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    // present one word from the falling edge; hold until accepted
    task automatic send_word(input t_cmd cmd, input logic [31:0] a, input logic [31:0] b);
        while (!calm && $urandom_range(99) < 9) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
    endtask

    initial begin
        t_cmd cmd;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: every command at the range ends
        for (int c = 0; c < 16; c++)
            send_word(t_cmd'(c), 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(CMD_DIV, 32'h0000_0100, 32'h0000_0000);   // divide by zero
        send_word(CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF);   // overflowing divide
        send_word(CMD_MUL, 32'h8000_0000, 32'h8000_0000);   // huge product
        send_word(CMD_MUL, 32'h0000_0080, 32'hFFFF_FF01);   // rounding half
        send_word(CMD_INC, 32'h7FFF_FFFF, 32'h0);
        send_word(CMD_DEC, 32'h8000_0000, 32'h0);
        send_word(CMD_FROM_INT, 32'hFF80_0000, 32'h0);      // lowest exact
        send_word(CMD_TO_INT, 32'hFFFF_FFFF, 32'h0);        // rounds to -1
        send_word(CMD_EQ, 32'h1234_5678, 32'h1234_5678);
        i_in_valid <= 1'b0;

        // sender holds off until the pipeline drains
        while (pending != 0) @(negedge i_clk);

        for (int i = 0; i < N_RANDOM; i++) begin
            calm = (i >= 300 && i < 400);
            cmd = t_cmd'($urandom_range(15));
            send_word(cmd, pick_operand(), pick_operand());
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);

        $display("Sent %0d words over all 16 commands, corner operands and random stalls;",
                 words_sent);
        $display("checked %0d result words.", results);
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

[sim.f]
src/fxa_pkg.sv
src/fxa_div_stage.sv
src/fixed_point_alu_q24_8.sv
tb/fxa_checker.sv
tb/tb_fixed_point_alu_q24_8.sv
